// ----- rtl/tsc_pkg.sv -----
// Shared types, codes and constants of the tile slot cache manager.
`timescale 1ns / 1ps
`default_nettype none
package tsc_pkg;

	// Default sizes for the top-level parameters.
	localparam int MAX_SLOTS_DEF = 256;
	localparam int KEY_WIDTH_DEF = 32;

	// Slot numbers are eight bits wide, so no pool holds more slots than this.
	localparam int SLOT_SPACE = 256;

	// Field widths of the request and result items.
	localparam int KIND_W   = 3;
	localparam int TILE_W   = 32;
	localparam int SLOT_W   = 8;
	localparam int STATUS_W = 3;
	localparam int OFFSET_W = 24;

	// Register widths and limits.
	localparam int COUNT_REG_W = 9;
	localparam int TB_W        = 17;
	localparam int CFG_IDX_W   = 1;
	localparam logic [TB_W-1:0] TILE_BYTES_MAX = TB_W'(65536);
	localparam logic [TB_W-1:0] TILE_BYTES_RST = TB_W'(4096);

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_BYTES = 1'b1;

	// Operation codes.
	localparam logic [KIND_W-1:0] K_RESERVE     = 3'd0;
	localparam logic [KIND_W-1:0] K_COMMIT      = 3'd1;
	localparam logic [KIND_W-1:0] K_RELEASE     = 3'd2;
	localparam logic [KIND_W-1:0] K_RELEASE_UNC = 3'd3;
	localparam logic [KIND_W-1:0] K_LOOKUP      = 3'd4;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FREE   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_LOADED    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [TILE_W-1:0] tile_index;
		logic [SLOT_W-1:0] slot;
	} req_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot_out;
		logic [OFFSET_W-1:0] byte_offset;
	} rsp_item_t;

	// Control from the sequencer to the key scanner.
	typedef struct packed {
		logic start;
		logic wr_en;
	} scan_req_t;

	// Status from the key scanner back to the sequencer.
	typedef struct packed {
		logic done;
		logic hit;
	} scan_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/tile_slot_cache_manager.sv -----
// Top level of the tile slot cache manager: sequencer, free stack and slot map.
// Searching requests scan the key store one slot per cycle, then pass the decide, multiply and output
// states to the result; a reserve that pops adds the stack state, and an early hit ends the scan sooner.
// Release of an uncommitted slot and unknown kinds skip the search and go straight to the decide state.
// A request is accepted the cycle after the previous result loads, and none while one is in flight.
// Asynchronous reset: full slot limit, all free, none bound; a low-water mark replaces a refill.
`timescale 1ns / 1ps
`default_nettype none
module tile_slot_cache_manager import tsc_pkg::*; #(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire req_item_t            req_data,
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	output rsp_item_t                 rsp_data,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [TB_W-1:0]      cfg_data
);

	localparam int SLOT_LIMIT = (MAX_SLOTS < SLOT_SPACE) ? MAX_SLOTS : SLOT_SPACE;
	localparam int SW = $clog2(SLOT_LIMIT);
	localparam int CW = $clog2(SLOT_LIMIT + 1);
	localparam logic [COUNT_REG_W-1:0] LIMIT_REG = COUNT_REG_W'(SLOT_LIMIT);

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_SCAN    = 6'b000010,
		S_DECIDE  = 6'b000100,
		S_STACK   = 6'b001000,
		S_MUL     = 6'b010000,
		S_OUT     = 6'b100000
	} state_t;

	state_t                 state_q;
	logic [KIND_W-1:0]      kind_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [CW-1:0]          slot_count_q;
	logic [TB_W-1:0]        tile_bytes_q;
	logic [CW-1:0]          free_count_q;
	logic [CW-1:0]          lwm_q;
	logic [SLOT_LIMIT-1:0]  bound_q;
	logic [STATUS_W-1:0]    status_q;
	logic [SW-1:0]          res_q;
	logic                   use_mem_q;
	logic [SW-1:0]          fill_val_q;
	logic [OFFSET_W-1:0]    off_q;
	logic                   rsp_valid_q;
	rsp_item_t              rsp_q;

	logic [SW-1:0]          free_stack [SLOT_LIMIT];
	logic [SW-1:0]          stk_rd_s1;

	scan_req_t              scan_ctl;
	scan_rsp_t              scan_sts;
	logic [SW-1:0]          hit_slot;

	logic                   accept;
	logic                   rsp_take;
	logic                   rsp_load;
	logic                   cfg_count_wr;
	logic                   cfg_tb_wr;
	logic [COUNT_REG_W-1:0] cfg_count_clamped;
	logic [TB_W-1:0]        cfg_tb_clamped;

	logic [COUNT_REG_W-1:0] slot_ext;
	logic [COUNT_REG_W-1:0] count_ext;
	logic                   slot_in_range;
	logic                   slot_is_bound;
	logic                   stack_full;
	logic                   stack_empty;
	logic [CW-1:0]          pop_pos;

	logic [STATUS_W-1:0]    dec_status;
	logic [SW-1:0]          dec_res;
	logic                   do_pop;
	logic                   do_commit;
	logic                   do_unbind;
	logic                   do_push;
	logic [SW-1:0]          push_val;

	logic [SLOT_W+TB_W-1:0] product;

	assign accept    = req_valid && state_q == S_IDLE;
	assign req_stall = state_q != S_IDLE;
	assign rsp_take  = rsp_valid_q && !rsp_stall;
	assign rsp_load  = state_q == S_OUT && (!rsp_valid_q || !rsp_stall);

	// Register writes, clamped to the slot limit and to the largest tile.
	assign cfg_count_wr = cfg_we && cfg_index == REG_SLOT_COUNT;
	assign cfg_tb_wr    = cfg_we && cfg_index == REG_TILE_BYTES;
	assign cfg_count_clamped = (cfg_data[COUNT_REG_W-1:0] > LIMIT_REG) ?
		LIMIT_REG : cfg_data[COUNT_REG_W-1:0];
	assign cfg_tb_clamped = (cfg_data > TILE_BYTES_MAX) ? TILE_BYTES_MAX : cfg_data;

	// Conditions that the decision step looks at.
	assign slot_ext      = COUNT_REG_W'(slot_q);
	assign count_ext     = COUNT_REG_W'(slot_count_q);
	assign slot_in_range = slot_ext < count_ext;
	assign slot_is_bound = bound_q[slot_q[SW-1:0]];
	assign stack_full    = free_count_q >= slot_count_q;
	assign stack_empty   = free_count_q == '0;
	assign pop_pos       = free_count_q - CW'(1);

	// Decide the status and the state changes of one request.
	always_comb begin
		dec_status = ST_NOT_FOUND;
		dec_res    = '0;
		do_pop     = 1'b0;
		do_commit  = 1'b0;
		do_unbind  = 1'b0;
		do_push    = 1'b0;
		push_val   = hit_slot;
		unique case (kind_q)
			K_RESERVE: begin
				if (scan_sts.hit) begin
					dec_status = ST_LOADED;
				end else if (stack_empty) begin
					dec_status = ST_NO_FREE;
				end else begin
					dec_status = ST_OK;
					do_pop     = 1'b1;
				end
			end
			K_COMMIT: begin
				if (scan_sts.hit) begin
					dec_status = ST_LOADED;
				end else if (!slot_in_range) begin
					dec_status = ST_NOT_FOUND;
				end else if (slot_is_bound) begin
					dec_status = ST_LOADED;
				end else begin
					dec_status = ST_OK;
					dec_res    = slot_q[SW-1:0];
					do_commit  = 1'b1;
				end
			end
			K_RELEASE: begin
				if (!scan_sts.hit) begin
					dec_status = ST_NOT_FOUND;
				end else if (stack_full) begin
					dec_status = ST_FULL;
				end else begin
					dec_status = ST_OK;
					dec_res    = hit_slot;
					do_unbind  = 1'b1;
					do_push    = 1'b1;
				end
			end
			K_RELEASE_UNC: begin
				push_val = slot_q[SW-1:0];
				if (!slot_in_range) begin
					dec_status = ST_NOT_FOUND;
				end else if (slot_is_bound) begin
					dec_status = ST_LOADED;
				end else if (stack_full) begin
					dec_status = ST_FULL;
				end else begin
					dec_status = ST_OK;
					dec_res    = slot_q[SW-1:0];
					do_push    = 1'b1;
				end
			end
			K_LOOKUP: begin
				if (scan_sts.hit) begin
					dec_status = ST_OK;
					dec_res    = hit_slot;
				end
			end
			default: begin
				dec_status = ST_NOT_FOUND;
			end
		endcase
	end

	// Scanner control: start on every request that needs the key search.
	assign scan_ctl.start = accept && req_data.kind != K_RELEASE_UNC &&
		req_data.kind <= K_LOOKUP;
	assign scan_ctl.wr_en = state_q == S_DECIDE && do_commit;

	tsc_key_scan #(
		.MAX_SLOTS (MAX_SLOTS),
		.KEY_WIDTH (KEY_WIDTH)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.wr_addr  (slot_q[SW-1:0]),
		.wr_key   (key_q),
		.key      (key_q),
		.count    (slot_count_q),
		.bound    (bound_q),
		.sts      (scan_sts),
		.hit_slot (hit_slot)
	);

	// Free stack memory: one push port and one registered read port.
	always_ff @(posedge clk) begin
		if (state_q == S_DECIDE && do_push) begin
			free_stack[free_count_q[SW-1:0]] <= push_val;
		end
		stk_rd_s1 <= free_stack[pop_pos[SW-1:0]];
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slot_count_q <= CW'(SLOT_LIMIT);
			free_count_q <= CW'(SLOT_LIMIT);
			lwm_q        <= CW'(SLOT_LIMIT);
			tile_bytes_q <= TILE_BYTES_RST;
			bound_q      <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_take) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= scan_ctl.start ? S_SCAN : S_DECIDE;
					end
				end
				S_SCAN: begin
					if (scan_sts.done) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (do_pop) begin
						free_count_q <= pop_pos;
						if (pop_pos < lwm_q) begin
							lwm_q <= pop_pos;
						end
					end
					if (do_push) begin
						free_count_q <= free_count_q + CW'(1);
					end
					if (do_commit) begin
						bound_q[slot_q[SW-1:0]] <= 1'b1;
					end
					if (do_unbind) begin
						bound_q[hit_slot] <= 1'b0;
					end
					state_q <= do_pop ? S_STACK : S_MUL;
				end
				S_STACK: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// The user makes register writes only while the block is idle; not enforced.
			if (cfg_count_wr) begin
				slot_count_q <= CW'(cfg_count_clamped);
				free_count_q <= CW'(cfg_count_clamped);
				lwm_q        <= CW'(cfg_count_clamped);
				bound_q      <= '0;
			end
			if (cfg_tb_wr) begin
				tile_bytes_q <= cfg_tb_clamped;
			end
		end
	end

	// Byte offset: one multiply of the slot by the tile size.
	assign product = SLOT_W'(res_q) * tile_bytes_q;

	// Request payload, decision results and the result register.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= req_data.kind;
			key_q  <= KEY_WIDTH'(req_data.tile_index);
			slot_q <= req_data.slot;
		end
		if (state_q == S_DECIDE) begin
			status_q <= dec_status;
			res_q    <= dec_res;
			// Entries below the low-water mark still hold their refill value.
			use_mem_q  <= pop_pos >= lwm_q;
			fill_val_q <= SW'(slot_count_q - free_count_q);
		end
		if (state_q == S_STACK) begin
			res_q <= use_mem_q ? stk_rd_s1 : fill_val_q;
		end
		if (state_q == S_MUL) begin
			off_q <= product[OFFSET_W-1:0];
		end
		if (rsp_load) begin
			rsp_q.status      <= status_q;
			rsp_q.slot_out    <= SLOT_W'(res_q);
			rsp_q.byte_offset <= off_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// The free stack never holds more entries than the pool has slots.
	a_free_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= slot_count_q)
		else $error("free count above slot count");

	// Entries below the low-water mark are never live above the stack top.
	a_lwm_le_free: assert property (@(posedge clk) disable iff (!arst_n)
		lwm_q <= free_count_q)
		else $error("low-water mark above free count");

	// A failed request reports neither a slot nor an offset.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.status != ST_OK) |->
		(rsp_data.slot_out == '0 && rsp_data.byte_offset == '0))
		else $error("failed request carries a slot or offset");

	// A bound slot always lies inside the pool.
	a_commit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && do_commit) |-> slot_in_range)
		else $error("commit outside the pool");

endmodule
`default_nettype wire

// ----- rtl/tsc_key_scan.sv -----
// Key store and sequential key search over the bound slots.
`timescale 1ns / 1ps
`default_nettype none
module tsc_key_scan import tsc_pkg::*; #(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF,
	localparam int SLOT_LIMIT = (MAX_SLOTS < SLOT_SPACE) ? MAX_SLOTS : SLOT_SPACE,
	localparam int SW = $clog2(SLOT_LIMIT),
	localparam int CW = $clog2(SLOT_LIMIT + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire scan_req_t             ctl,
	input  wire logic [SW-1:0]         wr_addr,
	input  wire logic [KEY_WIDTH-1:0]  wr_key,
	input  wire logic [KEY_WIDTH-1:0]  key,
	input  wire logic [CW-1:0]         count,
	input  wire logic [SLOT_LIMIT-1:0] bound,
	output scan_rsp_t                  sts,
	output logic [SW-1:0]              hit_slot
);

	logic [KEY_WIDTH-1:0] key_mem [SLOT_LIMIT];
	logic [KEY_WIDTH-1:0] rd_key_s1;
	logic [SW-1:0]        rd_idx_s1;
	logic                 rd_vld_s1;
	logic [CW-1:0]        issue_q;
	logic                 busy_q;
	logic                 done_q;
	logic                 hit_q;
	logic [SW-1:0]        hit_slot_q;
	logic                 issue_go;
	logic                 match;

	// While a scan runs, one key leaves the memory each cycle; the compare sees it the cycle after.
	assign issue_go = busy_q && !hit_q && (issue_q < count);
	assign match    = rd_vld_s1 && !hit_q && bound[rd_idx_s1] && (rd_key_s1 == key);

	// Key memory with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			key_mem[wr_addr] <= wr_key;
		end
		rd_key_s1 <= key_mem[issue_q[SW-1:0]];
		rd_idx_s1 <= issue_q[SW-1:0];
	end

	// Scan control: walk the slots in order and stop at the lowest match.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q   <= '0;
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			hit_q     <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else if (ctl.start) begin
			issue_q   <= '0;
			busy_q    <= 1'b1;
			done_q    <= 1'b0;
			hit_q     <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else if (busy_q) begin
			rd_vld_s1 <= issue_go && !match;
			if (issue_go) begin
				issue_q <= issue_q + CW'(1);
			end
			if (match) begin
				hit_q <= 1'b1;
			end
			if (match || (!issue_go && !rd_vld_s1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// The matching slot number is payload and needs no reset.
	always_ff @(posedge clk) begin
		if (busy_q && match) begin
			hit_slot_q <= rd_idx_s1;
		end
	end

	assign sts.done = done_q;
	assign sts.hit  = hit_q;
	assign hit_slot = hit_slot_q;

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the tile slot cache manager: directed table, then random phases.
`timescale 1ns / 1ps
module tb;
	import tsc_pkg::*;

	localparam int POOL_LIMIT = (MAX_SLOTS_DEF < SLOT_SPACE) ? MAX_SLOTS_DEF : SLOT_SPACE;
	localparam int IDLE_PCT   = 38;
	localparam int STALL_LIMIT = 4000;
	localparam int END_WAIT   = 300;
	localparam int KEY_POOL   = 6;
	localparam int NPHASE     = 12;

	// Directed stimulus row: either a register write or a request.
	typedef struct {
		bit                   is_reg;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [TB_W-1:0]      reg_val;
		req_item_t            rq;
		bit                   typed;
		rsp_item_t            want;
	} dir_row_t;

	// Progress through a reserve, commit, lookup, release sequence.
	typedef enum {PLAN_IDLE, PLAN_BIND, PLAN_FIND, PLAN_DROP} plan_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_item_t            req_data  = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_item_t            rsp_data;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TB_W-1:0]      cfg_data  = '0;

	tile_slot_cache_manager dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the pool: registers, free stack and slot map.
	logic [COUNT_REG_W-1:0] pool_count;
	logic [TB_W-1:0]        pool_bytes;
	logic [SLOT_W-1:0]      spare_stack [POOL_LIMIT];
	logic [COUNT_REG_W-1:0] spare_top;
	logic [TILE_W-1:0]      bind_key [POOL_LIMIT];
	logic                   bind_flag [POOL_LIMIT];

	rsp_item_t  due_results [$];
	rsp_item_t  last_result;
	rsp_item_t  head;
	dir_row_t   dir_rows [$];
	int         errors = 0;
	int         quiet_cycles = 0;
	bit         calm = 1'b0;

	int unsigned ph_count [NPHASE] = '{2, 8, 1, 16, 0, 300, 5, 32, 3, 511, 12, 256};
	int unsigned ph_bytes [NPHASE] = '{1, 65536, 131071, 777, 0, 4096, 65535, 2, 100000, 3,
		0, 65536};

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Refill the free stack so that slot 0 is on top, and drop every binding.
	function automatic void pool_refill();
		for (int i = 0; i < POOL_LIMIT; i++) begin
			spare_stack[i] = (i < pool_count) ? SLOT_W'(pool_count - 1 - i) : '0;
			bind_flag[i] = 1'b0;
			bind_key[i] = '0;
		end
		spare_top = pool_count;
	endfunction

	// Register write as seen by the shadow pool.
	function automatic void pool_write(input logic [CFG_IDX_W-1:0] idx, input logic [TB_W-1:0] val);
		logic [COUNT_REG_W-1:0] c;
		if (idx == REG_SLOT_COUNT) begin
			c = val[COUNT_REG_W-1:0];
			pool_count = (c > POOL_LIMIT) ? COUNT_REG_W'(POOL_LIMIT) : c;
			pool_refill();
		end else begin
			pool_bytes = (val > TILE_BYTES_MAX) ? TILE_BYTES_MAX : val;
		end
	endfunction

	// Lowest bound slot holding the key, or -1.
	function automatic int find_bound(input logic [TILE_W-1:0] key);
		for (int i = 0; i < pool_count; i++)
			if (bind_flag[i] && bind_key[i] == key)
				return i;
		return -1;
	endfunction

	// Apply one request to the shadow pool and return the result it must produce.
	function automatic rsp_item_t pool_apply(input req_item_t rq);
		rsp_item_t           r;
		logic [STATUS_W-1:0] st;
		logic [SLOT_W-1:0]   res;
		logic [31:0]         prod;
		int                  f;
		st = ST_NOT_FOUND;
		res = '0;
		f = find_bound(rq.tile_index);
		case (rq.kind)
			K_RESERVE: begin
				if (f >= 0) begin
					st = ST_LOADED;
				end else if (spare_top == 0) begin
					st = ST_NO_FREE;
				end else begin
					spare_top = spare_top - 1;
					res = spare_stack[spare_top];
					st = ST_OK;
				end
			end
			K_COMMIT: begin
				if (f >= 0) begin
					st = ST_LOADED;
				end else if (rq.slot >= pool_count) begin
					st = ST_NOT_FOUND;
				end else if (bind_flag[rq.slot]) begin
					st = ST_LOADED;
				end else begin
					bind_flag[rq.slot] = 1'b1;
					bind_key[rq.slot] = rq.tile_index;
					res = rq.slot;
					st = ST_OK;
				end
			end
			K_RELEASE: begin
				if (f < 0) begin
					st = ST_NOT_FOUND;
				end else if (spare_top >= pool_count) begin
					st = ST_FULL;
				end else begin
					bind_flag[f] = 1'b0;
					spare_stack[spare_top] = SLOT_W'(f);
					spare_top = spare_top + 1;
					res = SLOT_W'(f);
					st = ST_OK;
				end
			end
			K_RELEASE_UNC: begin
				if (rq.slot >= pool_count) begin
					st = ST_NOT_FOUND;
				end else if (bind_flag[rq.slot]) begin
					st = ST_LOADED;
				end else if (spare_top >= pool_count) begin
					st = ST_FULL;
				end else begin
					spare_stack[spare_top] = rq.slot;
					spare_top = spare_top + 1;
					res = rq.slot;
					st = ST_OK;
				end
			end
			K_LOOKUP: begin
				if (f >= 0) begin
					res = SLOT_W'(f);
					st = ST_OK;
				end
			end
			default: begin
				st = ST_NOT_FOUND;
			end
		endcase
		if (st != ST_OK)
			res = '0;
		prod = 32'(res) * 32'(pool_bytes);
		r.status = st;
		r.slot_out = res;
		r.byte_offset = prod[OFFSET_W-1:0];
		return r;
	endfunction

	// One line per wrong field, with a cap on printing.
	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		if (errors <= 60)
			$display("ERROR at %0t ns: %s got %0d, want %0d", $time, what, got, want);
	endtask

	// Table builders for the directed part.
	task automatic add_row(input logic [KIND_W-1:0] kind, input logic [TILE_W-1:0] key,
			input logic [SLOT_W-1:0] slot, input bit typed, input logic [STATUS_W-1:0] st,
			input logic [SLOT_W-1:0] so, input logic [OFFSET_W-1:0] off);
		dir_row_t row;
		row = '{default: '0};
		row.rq.kind = kind;
		row.rq.tile_index = key;
		row.rq.slot = slot;
		row.typed = typed;
		row.want.status = st;
		row.want.slot_out = so;
		row.want.byte_offset = off;
		dir_rows = {dir_rows, row};
	endtask

	task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TB_W-1:0] val);
		dir_row_t row;
		row = '{default: '0};
		row.is_reg = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		dir_rows = {dir_rows, row};
	endtask

	// Present one request, wait for it to be taken, and record what it must return.
	task automatic send_request(input req_item_t rq, input bit typed, input rsp_item_t want);
		rsp_item_t pred;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= rq;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pred = pool_apply(rq);
		due_results = {due_results, (typed ? want : pred)};
		last_result = pred;
	endtask

	// Stop sending and wait until every result has come back.
	task automatic drain();
		req_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Register write while the block is idle; the enable is dropped again before the task returns.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TB_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		pool_write(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Random requests, mostly well-formed sequences over a small set of keys.
	task automatic run_random(input int n);
		req_item_t         rq;
		plan_t             plan;
		logic [TILE_W-1:0] keys [KEY_POOL];
		logic [TILE_W-1:0] key;
		logic [SLOT_W-1:0] held;
		int                r;
		plan = PLAN_IDLE;
		key = '0;
		held = '0;
		for (int k = 0; k < KEY_POOL; k++)
			keys[k] = $urandom();
		keys[0] = '1;
		for (int i = 0; i < n; i++) begin
			rq = '0;
			r = $urandom_range(99);
			case (plan)
				PLAN_BIND: begin
					rq.tile_index = key;
					if (r < 75) begin
						rq.kind = K_COMMIT;
						rq.slot = held;
					end else if (r < 85) begin
						rq.kind = K_COMMIT;
						rq.slot = SLOT_W'($urandom_range(255));
					end else begin
						rq.kind = K_RELEASE_UNC;
						rq.slot = held;
					end
				end
				PLAN_FIND: begin
					rq.kind = K_LOOKUP;
					rq.tile_index = key;
				end
				PLAN_DROP: begin
					rq.kind = K_RELEASE;
					rq.tile_index = key;
				end
				default: begin
					rq.tile_index = keys[$urandom_range(KEY_POOL - 1)];
					if (r < 60) begin
						rq.kind = K_RESERVE;
					end else if (r < 72) begin
						rq.kind = K_RELEASE;
					end else if (r < 80) begin
						rq.kind = K_LOOKUP;
					end else begin
						// Noise: any kind, any key, a slot in or out of the pool.
						rq.kind = KIND_W'($urandom_range(7));
						rq.tile_index = $urandom();
						rq.slot = $urandom_range(1) ? SLOT_W'($urandom_range(255))
							: SLOT_W'($urandom_range(pool_count));
					end
				end
			endcase
			send_request(rq, 1'b0, '0);
			// Move the sequence on from the outcome the shadow pool predicts.
			case (plan)
				PLAN_IDLE: begin
					key = rq.tile_index;
					held = last_result.slot_out;
					plan = (rq.kind == K_RESERVE && last_result.status == ST_OK)
						? PLAN_BIND : PLAN_IDLE;
				end
				PLAN_BIND: begin
					plan = (rq.kind == K_COMMIT && last_result.status == ST_OK)
						? PLAN_FIND : PLAN_IDLE;
				end
				PLAN_FIND: begin
					plan = $urandom_range(1) ? PLAN_DROP : PLAN_IDLE;
				end
				default: begin
					plan = PLAN_IDLE;
				end
			endcase
		end
	endtask

	// Result checker and result-side stall.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (due_results.size() == 0) begin
					report_mismatch("result with no request due, status", rsp_data.status, 0);
				end else begin
					head = due_results.pop_front();
					if (rsp_data.status !== head.status)
						report_mismatch("status", rsp_data.status, head.status);
					if (rsp_data.slot_out !== head.slot_out)
						report_mismatch("slot_out", rsp_data.slot_out, head.slot_out);
					if (rsp_data.byte_offset !== head.byte_offset)
						report_mismatch("byte_offset", rsp_data.byte_offset, head.byte_offset);
				end
			end
			rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Watchdog: too long without any request, result or register write taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("ERROR at %0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("Mismatches found");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Main sequence: reset, directed table, random phases, final drain.
	initial begin
		logic [TB_W-1:0] val;
		int              n;
		pool_count = COUNT_REG_W'(POOL_LIMIT);
		pool_bytes = TILE_BYTES_RST;
		pool_refill();

		// Directed rows, starting from the reset pool of 256 slots at 4096 bytes.
		add_row(K_LOOKUP, 32'h0, 8'd0, 1, ST_NOT_FOUND, 8'd0, 24'd0);
		add_row(K_RESERVE, 32'hFFFF_FFFF, 8'd0, 1, ST_OK, 8'd0, 24'd0);
		add_row(K_COMMIT, 32'hFFFF_FFFF, 8'd0, 1, ST_OK, 8'd0, 24'd0);
		add_row(K_RESERVE, 32'hFFFF_FFFF, 8'd0, 1, ST_LOADED, 8'd0, 24'd0);
		add_row(K_COMMIT, 32'hFFFF_FFFF, 8'd5, 1, ST_LOADED, 8'd0, 24'd0);
		add_row(K_COMMIT, 32'h1, 8'd0, 1, ST_LOADED, 8'd0, 24'd0);
		add_row(K_LOOKUP, 32'hFFFF_FFFF, 8'd0, 1, ST_OK, 8'd0, 24'd0);
		add_row(K_RESERVE, 32'h2, 8'd0, 1, ST_OK, 8'd1, 24'd4096);
		add_row(K_COMMIT, 32'h2, 8'd255, 1, ST_OK, 8'd255, 24'd1044480);
		add_row(K_RELEASE_UNC, 32'h0, 8'd255, 1, ST_LOADED, 8'd0, 24'd0);
		add_row(K_RELEASE, 32'h2, 8'd0, 1, ST_OK, 8'd255, 24'd1044480);
		add_row(K_RELEASE_UNC, 32'h0, 8'd1, 1, ST_OK, 8'd1, 24'd4096);
		add_row(K_RELEASE_UNC, 32'h0, 8'd1, 1, ST_FULL, 8'd0, 24'd0);
		add_row(K_RELEASE, 32'hFFFF_FFFF, 8'd0, 1, ST_FULL, 8'd0, 24'd0);
		add_row(KIND_W'(7), 32'h1234_5678, 8'hAA, 1, ST_NOT_FOUND, 8'd0, 24'd0);
		add_row(K_RELEASE, 32'h3, 8'd0, 1, ST_NOT_FOUND, 8'd0, 24'd0);
		// Oversized tile size saturates; the top slot lands on the last whole tile of the offset range.
		add_reg(REG_TILE_BYTES, 17'd131071);
		add_row(K_RESERVE, 32'h9, 8'd0, 0, ST_OK, 8'd0, 24'd0);
		add_row(K_COMMIT, 32'h9, 8'd255, 1, ST_OK, 8'd255, 24'd16711680);
		// A single-slot pool, then an empty one.
		add_reg(REG_SLOT_COUNT, 17'd1);
		add_row(K_RESERVE, 32'h3, 8'd0, 1, ST_OK, 8'd0, 24'd0);
		add_row(K_RESERVE, 32'h4, 8'd0, 1, ST_NO_FREE, 8'd0, 24'd0);
		add_row(K_COMMIT, 32'h4, 8'd1, 1, ST_NOT_FOUND, 8'd0, 24'd0);
		add_row(K_RELEASE_UNC, 32'h0, 8'd255, 1, ST_NOT_FOUND, 8'd0, 24'd0);
		add_reg(REG_SLOT_COUNT, 17'd0);
		add_row(K_RESERVE, 32'h5, 8'd0, 1, ST_NO_FREE, 8'd0, 24'd0);
		add_row(K_RELEASE_UNC, 32'h0, 8'd0, 1, ST_NOT_FOUND, 8'd0, 24'd0);
		add_row(K_LOOKUP, 32'h5, 8'd0, 1, ST_NOT_FOUND, 8'd0, 24'd0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_reg) begin
				drain();
				write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
			end else begin
				send_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		// Random phases, each with its own pool size and tile size.
		for (int p = 0; p < NPHASE; p++) begin
			drain();
			val = (ph_bytes[p] == 0) ? TB_W'($urandom_range(65536, 1)) : TB_W'(ph_bytes[p]);
			write_reg(REG_TILE_BYTES, val);
			val = TB_W'(ph_count[p]);
			if ($urandom_range(1))
				val[TB_W-1:COUNT_REG_W] = (TB_W - COUNT_REG_W)'($urandom_range(255));
			write_reg(REG_SLOT_COUNT, val);
			calm = (p == 7);
			n = (pool_count >= POOL_LIMIT) ? 40 : 85;
			run_random(n);
		end
		calm = 1'b0;

		drain();
		repeat (END_WAIT) @(posedge clk);
		while (due_results.size() != 0) begin
			head = due_results.pop_front();
			report_mismatch("missing result, status", -1, head.status);
		end
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
